// ----- sv/i2cbb_pkg.sv -----
// Shared types and constants for the bit-banged I2C master.
// Holds the command and item-kind codes and the queue entry type; no dependencies.
package i2cbb_pkg;

  // Command codes as they arrive on the func field.
  localparam logic [2:0] FUNC_START = 3'd0;
  localparam logic [2:0] FUNC_STOP  = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_TICK  = 3'd4;

  // Item kinds after classification by the front end.
  localparam logic [2:0] KIND_START = 3'd0;
  localparam logic [2:0] KIND_STOP  = 3'd1;
  localparam logic [2:0] KIND_WRITE = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_TICK  = 3'd4;
  localparam logic [2:0] KIND_NOP   = 3'd5;

  // Configuration register index and reset value.
  localparam logic      REG_DELAY_TICKS   = 1'b0;
  localparam logic [15:0] DELAY_TICKS_RST = 16'd50;

  // Depth of the queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified item as held in the queue.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } qitem_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- sv/i2cbb_front.sv -----
// Front end of the I2C master: accepts items, classifies the func code and queues them.
// Depends on i2cbb_pkg.
module i2cbb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic [7:0]         in_data_byte,
  input  logic               in_send_ack,
  input  logic               in_sda_in,
  output i2cbb_pkg::qitem_t  head,
  output logic               head_valid,
  input  logic               head_take,
  output i2cbb_pkg::qstat_t  stat
);
  import i2cbb_pkg::*;

  qitem_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push, pop;
  qitem_t              cls;

  // Classify the incoming func code; unknown codes become no-operation items.
  always_comb begin
    cls.data_byte = in_data_byte;
    cls.send_ack  = in_send_ack;
    cls.sda_in    = in_sda_in;
    case (in_func)
      FUNC_START: cls.kind = KIND_START;
      FUNC_STOP:  cls.kind = KIND_STOP;
      FUNC_WRITE: cls.kind = KIND_WRITE;
      FUNC_READ:  cls.kind = KIND_READ;
      FUNC_TICK:  cls.kind = KIND_TICK;
      default:    cls.kind = KIND_NOP;
    endcase
  end

  // The queue stalls the source only when every entry is taken.
  assign in_stall   = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign pop        = head_take && (count_r != '0);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = in_stall;
  assign stat.empty = (count_r == '0);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- sv/i2cbb_engine.sv -----
// Back end of the I2C master: runs the line sequences and registers one result per item.
// Depends on i2cbb_pkg.
module i2cbb_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       delay_ticks,
  input  i2cbb_pkg::qitem_t head,
  input  logic              head_valid,
  output logic              head_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_scl,
  output logic              out_sda_out,
  output logic              out_busy_res,
  output logic              out_done_res,
  output logic [7:0]        out_read_data,
  output logic              out_ack_received,
  output logic              out_rejected
);
  import i2cbb_pkg::*;

  // Sequencer phases.
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START_D1 = 4'd1;
  localparam logic [3:0] PH_STOP_D1  = 4'd2;
  localparam logic [3:0] PH_STOP_D2  = 4'd3;
  localparam logic [3:0] PH_WR_LOW   = 4'd4;
  localparam logic [3:0] PH_WR_HIGH  = 4'd5;
  localparam logic [3:0] PH_WA_LOW   = 4'd6;
  localparam logic [3:0] PH_WA_HIGH  = 4'd7;
  localparam logic [3:0] PH_RD_HIGH  = 4'd8;
  localparam logic [3:0] PH_RD_LOW   = 4'd9;
  localparam logic [3:0] PH_RA_HIGH  = 4'd10;
  localparam logic [3:0] PH_RA_LOW   = 4'd11;

  logic [3:0]  phase_r, phase_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_flag_r, ack_flag_nxt;
  logic        ack_send_r, ack_send_nxt;
  logic [7:0]  rbyte_r, rbyte_nxt;
  logic        done_nxt, rej_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        o_scl_r, o_sda_r, o_busy_r, o_done_r, o_ack_r, o_rej_r;
  logic [7:0]  o_rdata_r;
  logic        fire;
  logic        cmd;
  logic [16:0] tick_inc;

  // An item is executed whenever the output register is free or being emptied.
  assign fire      = head_valid && (!out_valid_r || !out_stall);
  assign head_take = fire;
  assign cmd       = (head.kind == KIND_START) || (head.kind == KIND_STOP) ||
                     (head.kind == KIND_WRITE) || (head.kind == KIND_READ);
  assign tick_inc  = {1'b0, tick_r} + 17'd1;

  // Next state for one item.
  always_comb begin
    phase_nxt    = phase_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    tick_nxt     = tick_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    ack_flag_nxt = ack_flag_r;
    ack_send_nxt = ack_send_r;
    rbyte_nxt    = rbyte_r;
    done_nxt     = 1'b0;
    rej_nxt      = 1'b0;
    if (cmd) begin
      if (phase_r != PH_IDLE) begin
        rej_nxt = 1'b1;
      end else begin
        tick_nxt = '0;
        case (head.kind)
          KIND_START: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_START_D1;
          end
          KIND_STOP: begin
            sda_nxt   = 1'b0;
            phase_nxt = PH_STOP_D1;
          end
          KIND_WRITE: begin
            shift_nxt = head.data_byte;
            bit_nxt   = 3'd7;
            sda_nxt   = head.data_byte[7];
            phase_nxt = PH_WR_LOW;
          end
          default: begin
            shift_nxt    = '0;
            bit_nxt      = 3'd7;
            ack_send_nxt = head.send_ack;
            scl_nxt      = 1'b1;
            phase_nxt    = PH_RD_HIGH;
          end
        endcase
      end
    end else if (head.kind == KIND_TICK && phase_r != PH_IDLE) begin
      if (tick_inc >= {1'b0, delay_ticks}) begin
        // End of a delay interval: take the next step of the sequence.
        tick_nxt = '0;
        case (phase_r)
          PH_START_D1: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end
          PH_STOP_D1: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_STOP_D2;
          end
          PH_STOP_D2: begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end
          PH_WR_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_WR_HIGH;
          end
          PH_WR_HIGH: begin
            scl_nxt = 1'b0;
            if (bit_r == '0) begin
              sda_nxt   = 1'b1;
              phase_nxt = PH_WA_LOW;
            end else begin
              bit_nxt   = bit_r - 1'b1;
              sda_nxt   = shift_r[bit_r - 1'b1];
              phase_nxt = PH_WR_LOW;
            end
          end
          PH_WA_LOW: begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_WA_HIGH;
          end
          PH_WA_HIGH: begin
            ack_flag_nxt = head.sda_in;
            scl_nxt      = 1'b0;
            phase_nxt    = PH_IDLE;
            done_nxt     = 1'b1;
          end
          PH_RD_HIGH: begin
            if (head.sda_in) begin
              shift_nxt[bit_r] = 1'b1;
            end
            scl_nxt   = 1'b0;
            phase_nxt = PH_RD_LOW;
          end
          PH_RD_LOW: begin
            scl_nxt = 1'b1;
            if (bit_r == '0) begin
              sda_nxt   = !ack_send_r;
              phase_nxt = PH_RA_HIGH;
            end else begin
              bit_nxt   = bit_r - 1'b1;
              phase_nxt = PH_RD_HIGH;
            end
          end
          PH_RA_HIGH: begin
            scl_nxt   = 1'b0;
            phase_nxt = PH_RA_LOW;
          end
          PH_RA_LOW: begin
            sda_nxt   = 1'b1;
            rbyte_nxt = shift_r;
            phase_nxt = PH_IDLE;
            done_nxt  = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end else begin
        tick_nxt = tick_inc[15:0];
      end
    end
  end

  // Sequencer state advances only when an item is executed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_r      <= '0;
      shift_r    <= '0;
      tick_r     <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      ack_flag_r <= 1'b0;
      ack_send_r <= 1'b0;
      rbyte_r    <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      tick_r     <= tick_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      ack_flag_r <= ack_flag_nxt;
      ack_send_r <= ack_send_nxt;
      rbyte_r    <= rbyte_nxt;
    end
  end

  // Output register: holds a result until the receiver takes it.
  assign out_valid_nxt = fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_scl_r   <= scl_nxt;
      o_sda_r   <= sda_nxt;
      o_busy_r  <= (phase_nxt != PH_IDLE);
      o_done_r  <= done_nxt;
      o_rdata_r <= rbyte_nxt;
      o_ack_r   <= ack_flag_nxt;
      o_rej_r   <= rej_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl          = o_scl_r;
  assign out_sda_out      = o_sda_r;
  assign out_busy_res     = o_busy_r;
  assign out_done_res     = o_done_r;
  assign out_read_data    = o_rdata_r;
  assign out_ack_received = o_ack_r;
  assign out_rejected     = o_rej_r;

endmodule

// ----- sv/i2c_bitbang_master_core.sv -----
// Top level of the bit-banged I2C master: configuration register, front end and engine.
// Depends on i2cbb_pkg, i2cbb_front and i2cbb_engine.
//
// Usage: each input item carries a func code (start, stop, write byte, read byte or
// tick) with its data byte, acknowledge choice and the sampled SDA level. Every item,
// including unknown codes, produces exactly one result item showing the driven SCL and
// SDA levels, busy and done flags, the last read byte, the last acknowledge and a flag
// for a command that arrived while busy and was ignored.
// Throughput is one item per clock cycle while the receiver does not stall; the engine
// executes one queued item a cycle. An accepted input item passes through the
// four-entry queue and then the engine's output register before its result is taken.
// When the receiver stalls, the result is held in the output register and the queue
// fills; in_stall rises once all four entries are occupied.
// The delay_ticks register (byte address 0) is written over the APB-style port and
// resets to 50. Reset returns SCL and SDA to released high, the sequencer to idle and
// empties the queue; reset is synchronous and active low.
module i2c_bitbang_master_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_data_byte,
  input  logic        in_send_ack,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_read_data,
  output logic        out_ack_received,
  output logic        out_rejected,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cbb_pkg::*;

  logic [15:0] delay_r;
  logic        cfg_wr;
  qitem_t      head;
  logic        head_valid;
  logic        head_take;
  qstat_t      qstat;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DELAY_TICKS);
  assign prdata = (paddr[2] == REG_DELAY_TICKS) ? {16'd0, delay_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_TICKS_RST;
    end else if (cfg_wr) begin
      delay_r <= pwdata[15:0];
    end
  end

  // Front end: classification and queue.
  i2cbb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .in_send_ack  (in_send_ack),
    .in_sda_in    (in_sda_in),
    .head         (head),
    .head_valid   (head_valid),
    .head_take    (head_take),
    .stat         (qstat)
  );

  // Back end: bus sequencer and result register.
  i2cbb_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .delay_ticks      (delay_r),
    .head             (head),
    .head_valid       (head_valid),
    .head_take        (head_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl          (out_scl),
    .out_sda_out      (out_sda_out),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_ack_received (out_ack_received),
    .out_rejected     (out_rejected)
  );

`ifndef NO_ASSERTIONS
  // A finished sequence leaves the block idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  // A rejected command cannot also complete a sequence.
  a_rej_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> !out_done_res)
    else $error("rejected item also reported done");

  // The queue is never both full and empty.
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue status inconsistent");

  // The engine only takes an item that the queue holds.
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    head_take |-> !qstat.empty)
    else $error("engine took from an empty queue");
`endif

endmodule

// ----- test/tb_i2c_bitbang_master_core.sv -----
// Self-checking testbench for the bit-banged I2C master core.
// Drives command and tick items, predicts the SCL/SDA line levels and flags of every
// result item, and compares them field by field. Depends on i2cbb_pkg and the core.
module tb_i2c_bitbang_master_core;
  import i2cbb_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_REPORTS = 10;

  // Ways of choosing the sampled SDA level on tick items.
  localparam int SDA_LOW    = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_RANDOM = 2;

  // Sequencer phases of the predicted bus engine.
  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START_D1, SEQ_STOP_D1, SEQ_STOP_D2, SEQ_WR_LOW, SEQ_WR_HIGH,
    SEQ_WA_LOW, SEQ_WA_HIGH, SEQ_RD_HIGH, SEQ_RD_LOW, SEQ_RA_HIGH, SEQ_RA_LOW
  } seq_phase_e;

  // One result item as seen on the output channel.
  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       ack;
    logic       rejected;
  } bus_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_func;
  logic [7:0]  in_data_byte;
  logic        in_send_ack;
  logic        in_sda_in;
  logic        out_valid;
  logic        out_stall;
  logic        out_scl;
  logic        out_sda_out;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_read_data;
  logic        out_ack_received;
  logic        out_rejected;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predicted state of the bus engine and its delay register.
  seq_phase_e  seq_phase;
  logic [15:0] delay_reg;
  logic [3:0]  bit_cnt;
  logic [7:0]  shifter;
  logic [15:0] tick_cnt;
  logic        scl_lvl;
  logic        sda_lvl;
  logic        ack_seen;
  logic        ack_out;
  logic [7:0]  last_read;

  bus_result_t expected_bus_q[$];
  int          mismatch_count;
  int          cycle_count;
  bit          sender_gaps;
  bit          receiver_gaps;
  bit          hold_req;

  i2c_bitbang_master_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_data_byte     (in_data_byte),
    .in_send_ack      (in_send_ack),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scl          (out_scl),
    .out_sda_out      (out_sda_out),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_ack_received (out_ack_received),
    .out_rejected     (out_rejected),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the predicted engine by one accepted item and return the line levels.
  function automatic bus_result_t predict_line_levels(logic [2:0] func, logic [7:0] data,
                                                      logic ack, logic sda);
    bus_result_t res;
    logic        fin;
    logic [16:0] nxt;
    fin = 1'b0;
    res.rejected = 1'b0;
    if (func <= FUNC_READ) begin
      if (seq_phase != SEQ_IDLE) begin
        res.rejected = 1'b1;
      end else begin
        tick_cnt = '0;
        case (func)
          FUNC_START: begin
            sda_lvl = 1'b0;
            seq_phase = SEQ_START_D1;
          end
          FUNC_STOP: begin
            sda_lvl = 1'b0;
            seq_phase = SEQ_STOP_D1;
          end
          FUNC_WRITE: begin
            shifter = data;
            bit_cnt = 4'd7;
            sda_lvl = data[7];
            seq_phase = SEQ_WR_LOW;
          end
          default: begin
            shifter = '0;
            bit_cnt = 4'd7;
            ack_out = ack;
            scl_lvl = 1'b1;
            seq_phase = SEQ_RD_HIGH;
          end
        endcase
      end
    end else if (func == FUNC_TICK && seq_phase != SEQ_IDLE) begin
      nxt = {1'b0, tick_cnt} + 17'd1;
      if (nxt >= {1'b0, delay_reg}) begin
        // The delay has run out: carry out the next line change of the sequence.
        tick_cnt = '0;
        case (seq_phase)
          SEQ_START_D1: begin
            scl_lvl = 1'b0;
            seq_phase = SEQ_IDLE;
            fin = 1'b1;
          end
          SEQ_STOP_D1: begin
            scl_lvl = 1'b1;
            seq_phase = SEQ_STOP_D2;
          end
          SEQ_STOP_D2: begin
            sda_lvl = 1'b1;
            seq_phase = SEQ_IDLE;
            fin = 1'b1;
          end
          SEQ_WR_LOW: begin
            scl_lvl = 1'b1;
            seq_phase = SEQ_WR_HIGH;
          end
          SEQ_WR_HIGH: begin
            scl_lvl = 1'b0;
            if (bit_cnt == 4'd0) begin
              sda_lvl = 1'b1;
              seq_phase = SEQ_WA_LOW;
            end else begin
              bit_cnt = bit_cnt - 4'd1;
              sda_lvl = shifter[bit_cnt[2:0]];
              seq_phase = SEQ_WR_LOW;
            end
          end
          SEQ_WA_LOW: begin
            scl_lvl = 1'b1;
            seq_phase = SEQ_WA_HIGH;
          end
          SEQ_WA_HIGH: begin
            ack_seen = sda;
            scl_lvl = 1'b0;
            seq_phase = SEQ_IDLE;
            fin = 1'b1;
          end
          SEQ_RD_HIGH: begin
            if (sda) shifter[bit_cnt[2:0]] = 1'b1;
            scl_lvl = 1'b0;
            seq_phase = SEQ_RD_LOW;
          end
          SEQ_RD_LOW: begin
            if (bit_cnt == 4'd0) begin
              sda_lvl = ~ack_out;
              seq_phase = SEQ_RA_HIGH;
            end else begin
              bit_cnt = bit_cnt - 4'd1;
              seq_phase = SEQ_RD_HIGH;
            end
            scl_lvl = 1'b1;
          end
          SEQ_RA_HIGH: begin
            scl_lvl = 1'b0;
            seq_phase = SEQ_RA_LOW;
          end
          SEQ_RA_LOW: begin
            sda_lvl = 1'b1;
            last_read = shifter;
            seq_phase = SEQ_IDLE;
            fin = 1'b1;
          end
          default: seq_phase = SEQ_IDLE;
        endcase
      end else begin
        tick_cnt = nxt[15:0];
      end
    end
    res.scl = scl_lvl;
    res.sda_out = sda_lvl;
    res.busy = (seq_phase != SEQ_IDLE);
    res.done = fin;
    res.read_data = last_read;
    res.ack = ack_seen;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  // Offer one item, with an occasional random gap first, and wait until it is taken.
  task automatic send_item(input logic [2:0] func, input logic [7:0] data, input logic ack,
                           input logic sda);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_data_byte <= data;
    in_send_ack  <= ack;
    in_sda_in    <= sda;
    do @(posedge clk); while (in_stall);
    expected_bus_q.push_back(predict_line_levels(func, data, ack, sda));
  endtask

  // Tick the engine until the current sequence has finished.
  task automatic finish_sequence(input int sda_pick);
    logic sda;
    while (seq_phase != SEQ_IDLE) begin
      sda = (sda_pick == SDA_RANDOM) ? 1'($urandom) : (sda_pick == SDA_HIGH);
      send_item(FUNC_TICK, 8'($urandom), 1'($urandom), sda);
    end
  endtask

  // Write delay_ticks once the block has delivered every result.
  task automatic write_delay(input logic [15:0] value);
    in_valid <= 1'b0;
    while (expected_bus_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_DELAY_TICKS, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    delay_reg = value;
  endtask

  // Idle ticks and unknown codes, then a start with the reset delay.
  task automatic test_idle_items();
    send_item(FUNC_TICK, 8'hFF, 1'b1, 1'b1);
    send_item(3'd5, 8'h00, 1'b0, 1'b0);
    send_item(3'd6, 8'hFF, 1'b1, 1'b1);
    send_item(3'd7, 8'h5A, 1'b0, 1'b1);
    send_item(FUNC_START, 8'h00, 1'b0, 1'b0);
    finish_sequence(SDA_RANDOM);
  endtask

  // Stop, write and read commands with extreme data, both acknowledge levels and a rejected command.
  task automatic test_bus_commands();
    send_item(FUNC_STOP, 8'hFF, 1'b1, 1'b1);
    finish_sequence(SDA_RANDOM);
    send_item(FUNC_WRITE, 8'hFF, 1'b0, 1'b0);
    send_item(FUNC_TICK, 8'h00, 1'b0, 1'b1);
    send_item(FUNC_READ, 8'hFF, 1'b1, 1'b1);
    finish_sequence(SDA_HIGH);
    send_item(FUNC_WRITE, 8'h00, 1'b1, 1'b1);
    finish_sequence(SDA_LOW);
    send_item(FUNC_READ, 8'h00, 1'b1, 1'b0);
    finish_sequence(SDA_HIGH);
    send_item(FUNC_READ, 8'hFF, 1'b0, 1'b1);
    finish_sequence(SDA_LOW);
  endtask

  // A delay of zero behaves as a single tick.
  task automatic test_zero_delay();
    send_item(FUNC_START, 8'($urandom), 1'($urandom), 1'($urandom));
    finish_sequence(SDA_RANDOM);
    send_item(FUNC_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
    finish_sequence(SDA_RANDOM);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_back_pressure();
    hold_req = 1'b1;
    send_item(FUNC_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
    finish_sequence(SDA_RANDOM);
    send_item(FUNC_READ, 8'($urandom), 1'($urandom), 1'($urandom));
    finish_sequence(SDA_RANDOM);
  endtask

  // Mostly complete sequences with random content, with some noise in between.
  task automatic test_random_traffic(input int n);
    int counted;
    int pick;
    counted = 0;
    while (counted < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        send_item(3'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 1'($urandom));
        counted++;
        while (seq_phase != SEQ_IDLE) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            send_item(3'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                      1'($urandom));
            counted++;
          end else if (pick == 1) begin
            send_item(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom),
                      1'($urandom));
          end else begin
            send_item(FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
            counted++;
          end
        end
      end else if (pick == 8) begin
        send_item(FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        send_item(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  // A long delay, run once through a start condition.
  task automatic test_longest_delay();
    send_item(FUNC_START, 8'($urandom), 1'($urandom), 1'($urandom));
    finish_sequence(SDA_RANDOM);
  endtask

  // Receiver side: random stall bursts, or one long hold-off when asked.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (64) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result item with the oldest expectation.
  always @(posedge clk) begin
    bus_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bus_q.size() == 0) begin
        note_mismatch("unexpected result item", 1, 0);
      end else begin
        want = expected_bus_q.pop_front();
        if (out_scl !== want.scl)
          note_mismatch("scl", int'(out_scl), int'(want.scl));
        if (out_sda_out !== want.sda_out)
          note_mismatch("sda_out", int'(out_sda_out), int'(want.sda_out));
        if (out_busy_res !== want.busy)
          note_mismatch("busy_res", int'(out_busy_res), int'(want.busy));
        if (out_done_res !== want.done)
          note_mismatch("done_res", int'(out_done_res), int'(want.done));
        if (out_read_data !== want.read_data)
          note_mismatch("read_data", int'(out_read_data), int'(want.read_data));
        if (out_ack_received !== want.ack)
          note_mismatch("ack_received", int'(out_ack_received), int'(want.ack));
        if (out_rejected !== want.rejected)
          note_mismatch("rejected", int'(out_rejected), int'(want.rejected));
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int waited;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_func      <= FUNC_TICK;
    in_data_byte <= '0;
    in_send_ack  <= 1'b0;
    in_sda_in    <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    mismatch_count = 0;
    hold_req       = 1'b0;
    sender_gaps    = 1'b1;
    receiver_gaps  = 1'b1;
    seq_phase = SEQ_IDLE;
    delay_reg = DELAY_TICKS_RST;
    bit_cnt   = '0;
    shifter   = '0;
    tick_cnt  = '0;
    scl_lvl   = 1'b1;
    sda_lvl   = 1'b1;
    ack_seen  = 1'b0;
    ack_out   = 1'b0;
    last_read = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_items();
    write_delay(16'd1);
    test_bus_commands();
    write_delay(16'd0);
    test_zero_delay();
    write_delay(16'd2);
    test_back_pressure();
    write_delay(16'd1);
    test_random_traffic(50);
    write_delay(16'd2);
    test_random_traffic(50);
    write_delay(16'd3);
    test_random_traffic(50);
    write_delay(16'($urandom_range(1, 6)));
    test_random_traffic(50);

    // Last part of the run: no idling on either side.
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    write_delay(16'd24);
    test_longest_delay();

    in_valid <= 1'b0;
    waited = 0;
    while (expected_bus_q.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_bus_q.size() != 0)
      note_mismatch("result items missing", 0, expected_bus_q.size());
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
